// ----- rtl/udp_pbt_pkg.sv -----
// Package for the UDP port binding table.
// Holds the input and result word types, command and status codes and the match summary type.
// No dependencies.
package udp_pbt_pkg;

  localparam int UDP_HDR_BYTES = 8;
  localparam int SLOT_IDX_W    = 6;
  localparam int SLOT_OUT_W    = 3;

  localparam logic [1:0] CMD_BIND   = 2'd0;
  localparam logic [1:0] CMD_UNBIND = 2'd1;
  localparam logic [1:0] CMD_RECV   = 2'd2;
  localparam logic [1:0] CMD_NONE   = 2'd3;

  localparam logic [3:0] ST_BOUND_NEW   = 4'd0;
  localparam logic [3:0] ST_REBOUND     = 4'd1;
  localparam logic [3:0] ST_FULL        = 4'd2;
  localparam logic [3:0] ST_UNBOUND     = 4'd3;
  localparam logic [3:0] ST_UNBIND_MISS = 4'd4;
  localparam logic [3:0] ST_DELIVERED   = 4'd5;
  localparam logic [3:0] ST_SHORT       = 4'd6;
  localparam logic [3:0] ST_BAD_LENGTH  = 4'd7;
  localparam logic [3:0] ST_NO_HANDLER  = 4'd8;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] port;
    logic [7:0]  handler_id;
    logic [15:0] frame_length;
    logic [15:0] udp_length_field;
  } in_word_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [7:0]  handler_out;
    logic [15:0] payload_bytes;
    logic [2:0]  slot;
  } out_word_t;

  typedef struct packed {
    logic                  hit;
    logic [SLOT_IDX_W-1:0] hit_idx;
    logic                  free;
    logic [SLOT_IDX_W-1:0] free_idx;
  } match_t;

endpackage

// ----- rtl/udp_pbt_match.sv -----
// Port comparators and priority pick for the UDP port binding table.
// Finds the lowest valid entry holding a port and the lowest free entry.
// Depends on udp_pbt_pkg.
module udp_pbt_match
  import udp_pbt_pkg::*;
#(
  parameter int TABLE_ENTRIES = 8
) (
  input  logic [TABLE_ENTRIES-1:0] entry_valid,
  input  logic [15:0]              entry_port [TABLE_ENTRIES],
  input  logic [15:0]              port,
  output match_t                   match
);

  always_comb begin
    match = '0;
    for (int k = TABLE_ENTRIES - 1; k >= 0; k--) begin
      if (entry_valid[k] && entry_port[k] == port) begin
        match.hit     = 1'b1;
        match.hit_idx = SLOT_IDX_W'(k);
      end
      if (!entry_valid[k]) begin
        match.free     = 1'b1;
        match.free_idx = SLOT_IDX_W'(k);
      end
    end
  end

endmodule

// ----- rtl/udp_port_binding_table.sv -----
// UDP port binding table, top level.
// Holds the input and result registers, the binding table and command decode.
// Depends on udp_pbt_pkg and udp_pbt_match.
//
// Usage:
//   in_valid/in_ready/in_data carry one command word (bind, unbind, receive).
//   out_valid/out_ready/out_data carry one result word per bind, unbind or
//   receive command; an unused command code is consumed and gives no result.
//   The command waits in the input register; its result goes to the output
//   register, which drives out_valid, and waits while that register is full.
//   Throughput: one word per cycle while out_ready stays high. The table
//   lookup, the bind/unbind update and the length checks all complete
//   combinationally between the input register and the result register,
//   so back-to-back commands see each other's table updates.
//   Reset (rst_n low, synchronous) clears all valid marks, so the table is
//   empty, and empties both registers.
//   When the receiver holds out_ready low, the result stays in the output
//   register, the next command waits in the input register, and in_ready
//   drops once both are full.
module udp_port_binding_table
  import udp_pbt_pkg::*;
#(
  parameter int TABLE_ENTRIES = 8,
  parameter int HANDLER_BITS  = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int HB_USE = (HANDLER_BITS < 8) ? HANDLER_BITS : 8;

  logic                     s1_valid_r;
  in_word_t                 s1_data_r;
  logic                     out_valid_r;
  out_word_t                out_data_r;

  logic [TABLE_ENTRIES-1:0] entry_valid_r;
  logic [TABLE_ENTRIES-1:0] entry_valid_nxt;
  logic [15:0]              entry_port_r    [TABLE_ENTRIES];
  logic [HANDLER_BITS-1:0]  entry_handler_r [TABLE_ENTRIES];

  match_t                   match;
  logic [IDX_W-1:0]         hit_idx;
  logic [IDX_W-1:0]         free_idx;
  logic                     out_free;
  logic                     s1_fire;
  logic                     s1_has_result;
  out_word_t                res;
  logic                     hnd_we;
  logic                     port_we;
  logic [IDX_W-1:0]         wr_idx;
  logic [HANDLER_BITS-1:0]  hid;

  udp_pbt_match #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_match (
    .entry_valid (entry_valid_r),
    .entry_port  (entry_port_r),
    .port        (s1_data_r.port),
    .match       (match)
  );

  assign hit_idx  = match.hit_idx[IDX_W-1:0];
  assign free_idx = match.free_idx[IDX_W-1:0];
  assign hid      = HANDLER_BITS'(s1_data_r.handler_id[HB_USE-1:0]);

  assign out_free      = !out_valid_r || out_ready;
  assign s1_has_result = s1_data_r.cmd != CMD_NONE;
  assign s1_fire       = s1_valid_r && (!s1_has_result || out_free);
  assign in_ready      = !s1_valid_r || s1_fire;

  always_comb begin
    res             = '0;
    entry_valid_nxt = entry_valid_r;
    hnd_we          = 1'b0;
    port_we         = 1'b0;
    wr_idx          = hit_idx;
    case (s1_data_r.cmd)
      CMD_BIND: begin
        if (match.hit) begin
          res.status = ST_REBOUND;
          res.slot   = SLOT_OUT_W'(hit_idx);
          hnd_we     = 1'b1;
        end else if (match.free) begin
          res.status = ST_BOUND_NEW;
          res.slot   = SLOT_OUT_W'(free_idx);
          wr_idx     = free_idx;
          hnd_we     = 1'b1;
          port_we    = 1'b1;
          entry_valid_nxt[free_idx] = 1'b1;
        end else begin
          res.status = ST_FULL;
        end
      end
      CMD_UNBIND: begin
        if (match.hit) begin
          res.status = ST_UNBOUND;
          res.slot   = SLOT_OUT_W'(hit_idx);
          entry_valid_nxt[hit_idx] = 1'b0;
        end else begin
          res.status = ST_UNBIND_MISS;
        end
      end
      CMD_RECV: begin
        if (s1_data_r.frame_length < 16'(UDP_HDR_BYTES)) begin
          res.status = ST_SHORT;
        end else if (s1_data_r.udp_length_field > s1_data_r.frame_length ||
                     s1_data_r.udp_length_field < 16'(UDP_HDR_BYTES)) begin
          res.status = ST_BAD_LENGTH;
        end else if (match.hit) begin
          res.status        = ST_DELIVERED;
          res.handler_out   = 8'(entry_handler_r[hit_idx][HB_USE-1:0]);
          res.payload_bytes = s1_data_r.udp_length_field - 16'(UDP_HDR_BYTES);
          res.slot          = SLOT_OUT_W'(hit_idx);
        end else begin
          res.status = ST_NO_HANDLER;
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r    <= 1'b0;
      out_valid_r   <= 1'b0;
      entry_valid_r <= '0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_fire && s1_has_result) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (s1_fire) begin
        entry_valid_r <= entry_valid_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data_r <= in_data;
    end
    if (s1_fire && s1_has_result) begin
      out_data_r <= res;
    end
    if (s1_fire && hnd_we) begin
      entry_handler_r[wr_idx] <= hid;
    end
    if (s1_fire && port_we) begin
      entry_port_r[wr_idx] <= s1_data_r.port;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_bind_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_data_r.cmd == CMD_BIND && !match.hit && match.free
    |=> entry_valid_r[$past(free_idx)])
    else $error("bind into free slot did not mark it valid");

  a_unbind_clears: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_data_r.cmd == CMD_UNBIND && match.hit
    |=> !entry_valid_r[$past(hit_idx)])
    else $error("unbind left matched slot valid");

  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.status != ST_DELIVERED
    |-> out_data_r.handler_out == 8'd0 && out_data_r.payload_bytes == 16'd0)
    else $error("handler or payload length set on a non-delivered result");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !s1_valid_r && entry_valid_r == '0)
    else $error("reset did not empty the block");

endmodule

// ----- test/tb_udp_port_binding_table.sv -----
// Testbench for udp_port_binding_table: directed table then random command words, each result
// checked against the directed row's expected word or an in-bench model of the binding table.
// Depends on udp_pbt_pkg and the udp_port_binding_table RTL.
module tb_udp_port_binding_table
  import udp_pbt_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_SLOTS      = 8;
  localparam int PHASE_WORDS    = 200;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int DRAIN_CYCLES   = 6;
  localparam int HOLD_OFF_CYCLES = 60;

  typedef struct {
    in_word_t  w;
    bit        typed;
    out_word_t res;
  } dir_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_word_t out_data;

  logic        tbl_valid   [NUM_SLOTS];
  logic [15:0] tbl_port    [NUM_SLOTS];
  logic [7:0]  tbl_handler [NUM_SLOTS];

  out_word_t expected_results[$];
  dir_row_t  dir_rows[$];
  int        mismatch_count = 0;
  int        cycle_count    = 0;
  int        send_idle_pct  = 0;
  int        recv_idle_pct  = 0;
  int        hold_left      = 0;

  udp_port_binding_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic steer_predict(input in_word_t w, output bit produced, output out_word_t r);
    int k;
    int hit;
    int free_slot;
    r = '0;
    produced = 1'b1;
    hit = -1;
    free_slot = -1;
    for (k = 0; k < NUM_SLOTS; k++) begin
      if (hit < 0 && tbl_valid[k] && tbl_port[k] == w.port) hit = k;
      if (free_slot < 0 && !tbl_valid[k]) free_slot = k;
    end
    case (w.cmd)
      CMD_BIND: begin
        if (hit >= 0) begin
          tbl_handler[hit] = w.handler_id;
          r.status = ST_REBOUND;
          r.slot = 3'(hit);
        end else if (free_slot >= 0) begin
          tbl_valid[free_slot] = 1'b1;
          tbl_port[free_slot] = w.port;
          tbl_handler[free_slot] = w.handler_id;
          r.status = ST_BOUND_NEW;
          r.slot = 3'(free_slot);
        end else begin
          r.status = ST_FULL;
        end
      end
      CMD_UNBIND: begin
        if (hit >= 0) begin
          tbl_valid[hit] = 1'b0;
          r.status = ST_UNBOUND;
          r.slot = 3'(hit);
        end else begin
          r.status = ST_UNBIND_MISS;
        end
      end
      CMD_RECV: begin
        if (w.frame_length < 16'(UDP_HDR_BYTES)) begin
          r.status = ST_SHORT;
        end else if (w.udp_length_field > w.frame_length ||
                     w.udp_length_field < 16'(UDP_HDR_BYTES)) begin
          r.status = ST_BAD_LENGTH;
        end else if (hit >= 0) begin
          r.status = ST_DELIVERED;
          r.handler_out = tbl_handler[hit];
          r.payload_bytes = w.udp_length_field - 16'(UDP_HDR_BYTES);
          r.slot = 3'(hit);
        end else begin
          r.status = ST_NO_HANDLER;
        end
      end
      default: produced = 1'b0;
    endcase
  endtask

  task automatic send_word(input in_word_t w, input bit typed, input out_word_t typed_res);
    bit        produced;
    out_word_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    steer_predict(w, produced, r);
    if (produced) expected_results.push_back(typed ? typed_res : r);
    @(negedge clk);
  endtask

  function automatic logic [15:0] pick_port();
    case ($urandom_range(11))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'd53;
      3:       return 16'd67;
      4:       return 16'd68;
      5:       return 16'd123;
      6:       return 16'd161;
      7:       return 16'd514;
      8:       return 16'd5353;
      9:       return 16'h8000;
      10:      return 16'h7FFF;
      default: return 16'(16'd4789);
    endcase
  endfunction

  function automatic in_word_t gen_word();
    in_word_t    w;
    int          r;
    int          flen;
    logic [63:0] raw;
    w.port             = ($urandom_range(99) < 80) ? pick_port() : 16'($urandom);
    w.handler_id       = 8'($urandom);
    w.frame_length     = 16'($urandom);
    w.udp_length_field = 16'($urandom);
    r = $urandom_range(99);
    if (r < 5) begin
      w.cmd = CMD_NONE;
    end else if (r < 35) begin
      w.cmd = CMD_BIND;
    end else if (r < 55) begin
      w.cmd = CMD_UNBIND;
    end else begin
      w.cmd = CMD_RECV;
      r = $urandom_range(99);
      if (r < 70) begin
        flen = ($urandom_range(3) == 0) ? $urandom_range(65535, 8) : $urandom_range(300, 8);
        w.frame_length = 16'(flen);
        w.udp_length_field = 16'($urandom_range(flen, 8));
      end else if (r < 80) begin
        w.frame_length = 16'($urandom_range(7));
      end else if (r < 90) begin
        flen = $urandom_range(65534, 8);
        w.frame_length = 16'(flen);
        w.udp_length_field = 16'($urandom_range(65535, flen + 1));
      end else begin
        w.frame_length = 16'($urandom_range(65535, 8));
        w.udp_length_field = 16'($urandom_range(7));
      end
    end
    if ($urandom_range(99) < 4) begin
      raw = {$urandom, $urandom};
      w = raw[$bits(in_word_t)-1:0];
    end
    return w;
  endfunction

  always @(posedge clk) begin
    out_word_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result word: status %0d handler %0d payload %0d slot %0d",
                   out_data.status, out_data.handler_out, out_data.payload_bytes,
                   out_data.slot);
      end else begin
        e = expected_results.pop_front();
        if (out_data.status !== e.status || out_data.handler_out !== e.handler_out ||
            out_data.payload_bytes !== e.payload_bytes || out_data.slot !== e.slot) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch: exp status %0d handler %0d payload %0d slot %0d, got %0d %0d %0d %0d",
                     e.status, e.handler_out, e.payload_bytes, e.slot,
                     out_data.status, out_data.handler_out, out_data.payload_bytes,
                     out_data.slot);
        end
      end
    end
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    int        i;
    int        phase;
    int        sent;
    in_word_t  w;
    out_word_t none_res;

    none_res = '0;
    in_valid = 1'b0;
    in_data  = '0;
    rst_n    = 1'b0;
    for (i = 0; i < NUM_SLOTS; i++) begin
      tbl_valid[i] = 1'b0;
      tbl_port[i] = '0;
      tbl_handler[i] = '0;
    end

    dir_rows.push_back('{in_word_t'{CMD_RECV, 16'd80, 8'd0, 16'd100, 16'd50}, 1'b1,
                         out_word_t'{ST_NO_HANDLER, 8'd0, 16'd0, 3'd0}});
    dir_rows.push_back('{in_word_t'{CMD_UNBIND, 16'd80, 8'd0, 16'd0, 16'd0}, 1'b1,
                         out_word_t'{ST_UNBIND_MISS, 8'd0, 16'd0, 3'd0}});
    dir_rows.push_back('{in_word_t'{CMD_BIND, 16'd0, 8'd0, 16'd0, 16'd0}, 1'b1,
                         out_word_t'{ST_BOUND_NEW, 8'd0, 16'd0, 3'd0}});
    dir_rows.push_back('{in_word_t'{CMD_BIND, 16'hFFFF, 8'hFF, 16'd0, 16'd0}, 1'b1,
                         out_word_t'{ST_BOUND_NEW, 8'd0, 16'd0, 3'd1}});
    dir_rows.push_back('{in_word_t'{CMD_BIND, 16'd0, 8'hA5, 16'd0, 16'd0}, 1'b1,
                         out_word_t'{ST_REBOUND, 8'd0, 16'd0, 3'd0}});
    dir_rows.push_back('{in_word_t'{CMD_RECV, 16'd0, 8'd0, 16'hFFFF, 16'hFFFF}, 1'b1,
                         out_word_t'{ST_DELIVERED, 8'hA5, 16'd65527, 3'd0}});
    dir_rows.push_back('{in_word_t'{CMD_RECV, 16'hFFFF, 8'd0, 16'd8, 16'd8}, 1'b1,
                         out_word_t'{ST_DELIVERED, 8'hFF, 16'd0, 3'd1}});
    dir_rows.push_back('{in_word_t'{CMD_RECV, 16'd0, 8'd0, 16'd7, 16'd7}, 1'b1,
                         out_word_t'{ST_SHORT, 8'd0, 16'd0, 3'd0}});
    dir_rows.push_back('{in_word_t'{CMD_RECV, 16'd0, 8'd0, 16'd0, 16'd0}, 1'b1,
                         out_word_t'{ST_SHORT, 8'd0, 16'd0, 3'd0}});
    dir_rows.push_back('{in_word_t'{CMD_RECV, 16'd0, 8'd0, 16'd100, 16'd101}, 1'b1,
                         out_word_t'{ST_BAD_LENGTH, 8'd0, 16'd0, 3'd0}});
    dir_rows.push_back('{in_word_t'{CMD_RECV, 16'd0, 8'd0, 16'd100, 16'd7}, 1'b1,
                         out_word_t'{ST_BAD_LENGTH, 8'd0, 16'd0, 3'd0}});
    dir_rows.push_back('{in_word_t'{CMD_RECV, 16'd0, 8'd0, 16'hFFFF, 16'd0}, 1'b1,
                         out_word_t'{ST_BAD_LENGTH, 8'd0, 16'd0, 3'd0}});
    dir_rows.push_back('{in_word_t'{CMD_NONE, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF}, 1'b0,
                         none_res});
    for (i = 1; i <= 6; i++)
      dir_rows.push_back('{in_word_t'{CMD_BIND, 16'(i), 8'(i * 17), 16'd0, 16'd0}, 1'b0,
                           none_res});
    dir_rows.push_back('{in_word_t'{CMD_BIND, 16'd7, 8'd7, 16'd0, 16'd0}, 1'b1,
                         out_word_t'{ST_FULL, 8'd0, 16'd0, 3'd0}});
    dir_rows.push_back('{in_word_t'{CMD_UNBIND, 16'd0, 8'd0, 16'd0, 16'd0}, 1'b1,
                         out_word_t'{ST_UNBOUND, 8'd0, 16'd0, 3'd0}});
    dir_rows.push_back('{in_word_t'{CMD_BIND, 16'd9, 8'h3C, 16'd0, 16'd0}, 1'b0, none_res});
    dir_rows.push_back('{in_word_t'{CMD_RECV, 16'd9, 8'd0, 16'd64, 16'd40}, 1'b0, none_res});
    dir_rows.push_back('{in_word_t'{CMD_UNBIND, 16'hFFFF, 8'd0, 16'd0, 16'd0}, 1'b1,
                         out_word_t'{ST_UNBOUND, 8'd0, 16'd0, 3'd1}});
    dir_rows.push_back('{in_word_t'{CMD_RECV, 16'hFFFF, 8'd0, 16'd200, 16'd200}, 1'b1,
                         out_word_t'{ST_NO_HANDLER, 8'd0, 16'd0, 3'd0}});

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_idle_pct = 30;
    recv_idle_pct = 79;
    foreach (dir_rows[i]) send_word(dir_rows[i].w, dir_rows[i].typed, dir_rows[i].res);

    for (phase = 0; phase < 3; phase++) begin
      in_valid <= 1'b0;
      while (expected_results.size() != 0) @(negedge clk);
      case (phase)
        0: begin send_idle_pct = 30; recv_idle_pct = 79; end
        1: begin send_idle_pct = 79; recv_idle_pct = 30; end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          hold_left = HOLD_OFF_CYCLES;
        end
      endcase
      sent = 0;
      while (sent < PHASE_WORDS) begin
        w = gen_word();
        if (w.cmd != CMD_NONE) sent++;
        send_word(w, 1'b0, none_res);
      end
    end

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- udp_port_binding_table.f -----
rtl/udp_pbt_pkg.sv
rtl/udp_pbt_match.sv
rtl/udp_port_binding_table.sv
test/tb_udp_port_binding_table.sv
